// ----- src/set_assoc_lru_cache_level_macros.svh -----
// assertion macros used by the checker file
`ifndef SET_ASSOC_LRU_CACHE_LEVEL_MACROS_SVH
`define SET_ASSOC_LRU_CACHE_LEVEL_MACROS_SVH

// same-cycle implication, ignored while in reset
`define SALC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, ignored while in reset
`define SALC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/salc_pkg.sv -----
// ----------------------------------------------------------------------------
// salc_pkg
// shared types and constants of the set-associative lru cache level
// ----------------------------------------------------------------------------
package salc_pkg;

  localparam int ADDR_W      = 32;
  localparam int SETS        = 64;
  localparam int WAYS        = 4;
  localparam int BLOCK_BYTES = 64;
  localparam int USE_W       = 32;
  localparam int CNT_W       = 32;

  localparam int BLOCK_W = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;
  localparam int SET_W   = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int TAG_W   = ADDR_W - BLOCK_W;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WRITE_BACK = 2'd1;

  // one way of a set: full block number, last use time, dirty
  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [USE_W-1:0] last_use;
    logic             dirty;
  } way_t;

  typedef way_t [WAYS-1:0] row_t;

  localparam int ROW_W = $bits(row_t);

  typedef enum logic {
    ST_IDLE,
    ST_LOOKUP
  } ctl_state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;     // latch access word, start set read
    logic update;      // resolve access, write set, load result
    logic wb_pol;      // current policy
  } ctl_cmd_t;

  // result word
  typedef struct packed {
    logic              hit;
    logic              victim_writeback;
    logic [ADDR_W-1:0] victim_address;
    logic              forward_valid;
    logic [ADDR_W-1:0] forward_address;
    logic              forward_is_write;
    logic [CNT_W-1:0]  hit_count;
  } res_t;

endpackage

// ----- src/salc_ram.sv -----
// ----------------------------------------------------------------------------
// salc_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- src/salc_ctrl.sv -----
// ----------------------------------------------------------------------------
// salc_ctrl
// access sequencer, configuration registers and result valid
// ----------------------------------------------------------------------------
module salc_ctrl
  import salc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic                 cfg_data,
  output ctl_cmd_t             cmd
);

  ctl_state_t state_r, state_nxt;
  logic       enable_r, enable_nxt;
  logic       wb_r, wb_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;

  assign cfg_ready = 1'b1;

  always_comb begin
    enable_nxt = enable_r;
    wb_nxt     = wb_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ENABLE:     enable_nxt = cfg_data;
        REG_WRITE_BACK: wb_nxt     = cfg_data;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && enable_r) begin
          state_nxt = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall    = 1'b1;
    cmd.capture = 1'b0;
    cmd.update  = 1'b0;
    cmd.wb_pol  = wb_r;
    case (state_r)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid && enable_r;
      end
      ST_LOOKUP: begin
        cmd.update = !out_valid_r || !out_stall;
      end
      default: ;
    endcase
  end

  assign accept = in_valid && !in_stall;

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.update) begin
      out_valid_nxt = 1'b1;
    end
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      enable_r    <= 1'b0;
      wb_r        <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      enable_r    <= enable_nxt;
      wb_r        <= wb_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- src/salc_dpath.sv -----
// ----------------------------------------------------------------------------
// salc_dpath
// set store, tag match, lru pick, counters and result register
// ----------------------------------------------------------------------------
module salc_dpath
  import salc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  ctl_cmd_t          cmd,
  input  logic [ADDR_W-1:0] in_address,
  input  logic              in_cmd,
  output res_t              res
);

  logic [ADDR_W-1:0] addr_r;
  logic              wr_r;
  logic              row_ok_r;
  logic [SETS-1:0]   row_valid_r, row_valid_nxt;
  logic [USE_W-1:0]  clock_r, clock_nxt;
  logic [CNT_W-1:0]  hits_r, hits_nxt;
  res_t              res_r, res_nxt;

  logic [ROW_W-1:0]  rd_data;
  row_t              row, new_row;
  logic [TAG_W-1:0]  blk;
  logic [SET_W-1:0]  set_rd, set_wr;
  logic              hit;
  logic [WAY_W-1:0]  hit_way, lru;
  logic              vwb, fv;

  assign set_rd = in_address[BLOCK_W +: SET_W];
  assign blk    = addr_r[ADDR_W-1:BLOCK_W];
  assign set_wr = blk[SET_W-1:0];

  salc_ram #(
    .WIDTH(ROW_W),
    .DEPTH(SETS)
  ) u_ram (
    .clk  (clk),
    .we   (cmd.update),
    .waddr(set_wr),
    .wdata(new_row),
    .re   (cmd.capture),
    .raddr(set_rd),
    .rdata(rd_data)
  );

  // never-written sets read as cleared
  assign row = row_ok_r ? row_t'(rd_data) : row_t'('0);

  // first matching way
  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!hit && row[w].tag == blk) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
    end
  end

  // oldest use time, lowest way on ties
  always_comb begin
    lru = '0;
    for (int w = 1; w < WAYS; w++) begin
      if (row[w].last_use < row[lru].last_use) begin
        lru = WAY_W'(w);
      end
    end
  end

  assign clock_nxt = clock_r + 1'b1;

  always_comb begin
    new_row = row;
    if (hit) begin
      new_row[hit_way].last_use = clock_nxt;
      if (wr_r) begin
        new_row[hit_way].dirty = cmd.wb_pol;
      end
    end else begin
      new_row[lru].tag      = blk;
      new_row[lru].last_use = clock_nxt;
      new_row[lru].dirty    = wr_r && cmd.wb_pol;
    end
  end

  assign vwb = !hit && row[lru].dirty;
  assign fv  = hit ? (wr_r && !cmd.wb_pol) : (!wr_r || !cmd.wb_pol);

  always_comb begin
    hits_nxt = hits_r;
    if (hit && !(wr_r && !cmd.wb_pol)) begin
      hits_nxt = hits_r + 1'b1;
    end
  end

  always_comb begin
    res_nxt                  = res_r;
    res_nxt.hit              = hit;
    res_nxt.victim_writeback = vwb;
    res_nxt.victim_address   = vwb ? {row[lru].tag, {BLOCK_W{1'b0}}} : '0;
    res_nxt.forward_valid    = fv;
    res_nxt.forward_address  = fv ? {blk, {BLOCK_W{1'b0}}} : '0;
    res_nxt.forward_is_write = fv && wr_r;
    res_nxt.hit_count        = hits_nxt;
  end

  always_comb begin
    row_valid_nxt = row_valid_r;
    if (cmd.update) begin
      row_valid_nxt[set_wr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
      clock_r     <= '0;
      hits_r      <= '0;
    end else begin
      row_valid_r <= row_valid_nxt;
      if (cmd.update) begin
        clock_r <= clock_nxt;
        hits_r  <= hits_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      addr_r   <= in_address;
      wr_r     <= in_cmd;
      row_ok_r <= row_valid_r[set_rd];
    end
    if (cmd.update) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

// ----- src/set_assoc_lru_cache_level.sv -----
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_level
// one cache level, 64 sets x 4 ways, 64-byte blocks, timestamp lru
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake             word
//   in_      input      in_valid / in_stall   address, cmd
//   out_     output     out_valid / out_stall hit, victim, forward, hit count
//   cfg_     input      cfg_valid / cfg_ready index, data (enable, policy)
//
// an access is accepted in the idle state, which starts the set read; the
// lookup state then matches tags, picks the lru way and writes the set back
// in_stall is high in the lookup state, and stays high while the previous
// result word is still stalled in the output register
// reset clears the per-set valid bits, access clock and hit count at once;
// the block comes up disabled with write-back policy; disabled words are dropped
//
module set_assoc_lru_cache_level
  import salc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // access word
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [ADDR_W-1:0]    in_address,
  input  logic                 in_cmd,
  // result word
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_hit,
  output logic                 out_victim_writeback,
  output logic [ADDR_W-1:0]    out_victim_address,
  output logic                 out_forward_valid,
  output logic [ADDR_W-1:0]    out_forward_address,
  output logic                 out_forward_is_write,
  output logic [CNT_W-1:0]     out_hit_count,
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic                 cfg_data
);

  ctl_cmd_t cmd;
  res_t     res;

  // sequencer: accept, lookup, result valid, config registers
  salc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cmd      (cmd)
  );

  // set store and lookup logic
  salc_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_address(in_address),
    .in_cmd    (in_cmd),
    .res       (res)
  );

  // result word fields
  assign out_hit              = res.hit;
  assign out_victim_writeback = res.victim_writeback;
  assign out_victim_address   = res.victim_address;
  assign out_forward_valid    = res.forward_valid;
  assign out_forward_address  = res.forward_address;
  assign out_forward_is_write = res.forward_is_write;
  assign out_hit_count        = res.hit_count;

endmodule

// ----- src/salc_checker.sv -----
// ----------------------------------------------------------------------------
// salc_checker
// port-level checks of the cache level, bound to the top level
// ----------------------------------------------------------------------------
`include "set_assoc_lru_cache_level_macros.svh"

module salc_checker
  import salc_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic                 out_hit,
  input logic                 out_victim_writeback,
  input logic [ADDR_W-1:0]    out_victim_address,
  input logic                 out_forward_valid,
  input logic [ADDR_W-1:0]    out_forward_address,
  input logic                 out_forward_is_write,
  input logic [CNT_W-1:0]     out_hit_count
);

  // stalled result word holds
  `SALC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_victim_address) && $stable(out_forward_address) && $stable(out_hit_count), "stalled result changed")

  // write-back only on a miss, with a clean address otherwise
  `SALC_ASSERT_IMPLY(a_victim, clk, rst_n, out_valid, out_victim_writeback ? !out_hit : (out_victim_address == '0), "victim fields inconsistent")

  // no forward means zeroed forward fields
  `SALC_ASSERT_IMPLY(a_fwd_zero, clk, rst_n, out_valid && !out_forward_valid, (out_forward_address == '0) && !out_forward_is_write, "forward fields not cleared")

  // a hit is forwarded only as a write-through write
  `SALC_ASSERT_IMPLY(a_hit_fwd, clk, rst_n, out_valid && out_hit && out_forward_valid, out_forward_is_write, "hit forwarded as read")

endmodule

bind set_assoc_lru_cache_level salc_checker u_salc_checker (.*);
